### rtl/lasc_pkg.sv
// ----------------------------------------------------------------------------
// lasc_pkg
// Shared types and constants of the light aggregation stop controller.
// ----------------------------------------------------------------------------
package lasc_pkg;

   localparam int LASC_WINDOW_LEN = 10;

   localparam int LIGHT_W = 15;   // Q7.8 percent
   localparam int TIME_W  = 16;   // Q8.8 seconds
   localparam int NB_W    = 8;
   localparam int KIND_W  = 2;
   localparam int CODE_W  = 3;

   // Cooldown numerator: 10.0 s scaled so that the quotient lands in Q8.8.
   localparam int COOL_NUM   = 655360;
   localparam int COOL_NUM_W = 20;

   localparam logic [LIGHT_W-1:0] OPT_CAP         = 15'd23040; // 90.0 percent
   localparam logic [LIGHT_W-1:0] Q78_MAX         = 15'd32767;
   localparam logic [TIME_W-1:0]  TIME_MAX        = 16'hFFFF;
   localparam logic [LIGHT_W-1:0] MIN_LIGHT_RESET = 15'd0;
   localparam logic [LIGHT_W-1:0] TOLERANCE_RESET = 15'd1280;

   typedef enum logic [CODE_W-1:0] {
      REQ_TICK     = 3'd0,
      REQ_NEIGHBOR = 3'd1,
      REQ_RESET    = 3'd2,
      REQ_START    = 3'd3,
      REQ_STOP     = 3'd4
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      PUB_NONE  = 2'd0,
      PUB_LIGHT = 2'd1,
      PUB_RESET = 2'd2
   } pub_kind_type;

   typedef enum logic {
      CSR_MIN_LIGHT = 1'b0,
      CSR_LIGHT_TOL = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COOL,
      ST_MEAN_GO,
      ST_MEAN,
      ST_RESP
   } state_type;

endpackage

### rtl/lasc_divider.sv
// ----------------------------------------------------------------------------
// lasc_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lasc_divider
   import lasc_pkg::*;
#(
   parameter int DVD_W = 20,
   parameter int DVS_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   shifted;
   logic [DVS_W+1:0] diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      shifted  = {rem_ff, quo_ff[DVD_W-1]};
      diff     = {1'b0, shifted} - {2'b00, dvs_ff};
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
      end else if (busy_ff) begin
         // keep the partial remainder when the trial subtract borrows
         if (!diff[DVS_W+1]) begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/lasc_window.sv
// ----------------------------------------------------------------------------
// lasc_window
// Sliding window of accepted readings with a running sum and fill count.
// ----------------------------------------------------------------------------
module lasc_window
   import lasc_pkg::*;
#(
   parameter int WINDOW_LEN = LASC_WINDOW_LEN,
   parameter int SUM_W      = $clog2(WINDOW_LEN * 32767 + 1),
   parameter int FILL_W     = $clog2(WINDOW_LEN + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [LIGHT_W-1:0] push_value,
   output logic [SUM_W-1:0]   win_sum,
   output logic [FILL_W-1:0]  win_fill
);

   logic [LIGHT_W-1:0] win_ff [WINDOW_LEN];
   logic [LIGHT_W-1:0] win_in [WINDOW_LEN];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               full;

   assign full = (fill_ff == FILL_W'(WINDOW_LEN));

   always_comb begin
      win_in  = win_ff;
      sum_in  = sum_ff;
      fill_in = fill_ff;
      if (push) begin
         // drop the oldest entry once the window is full
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WINDOW_LEN-1] = push_value;
         if (full) begin
            sum_in = sum_ff + SUM_W'(push_value) - SUM_W'(win_ff[0]);
         end else begin
            sum_in  = sum_ff + SUM_W'(push_value);
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         fill_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         fill_ff <= fill_in;
      end
      win_ff <= win_in;
   end

   assign win_sum  = sum_ff;
   assign win_fill = fill_ff;

endmodule

### rtl/light_aggregation_stop_controller_core.sv
// ----------------------------------------------------------------------------
// light_aggregation_stop_controller_core
// Stop/go controller of a light-seeking swarm robot with one shared divider.
// ----------------------------------------------------------------------------
// The block takes one transaction at a time and answers each with exactly one
// result transaction. For control ticks, neighbor values and commands that
// need no division, the result is registered in the evaluation step and is
// valid in the response step after it. A tick that stops the robot with light
// above the minimum runs the shared restoring divider twice: first for the
// cooldown time, then for the new window mean. A neighbor value above the
// minimum runs the divider once, for the window mean. The divider retires one
// quotient bit per cycle. The result stays valid until rsp_ready takes it. The
// block is not ready while a transaction is in work or while its result waits
// to be taken. Configuration writes go through the csr_ port at any time the
// block is idle and take effect on the next transaction.
// ----------------------------------------------------------------------------
module light_aggregation_stop_controller_core
   import lasc_pkg::*;
#(
   parameter int WINDOW_LEN = LASC_WINDOW_LEN
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CODE_W-1:0]  req_type,
   input  logic [TIME_W-1:0]  req_elapsed_time,
   input  logic               req_motors_stopped,
   input  logic [LIGHT_W-1:0] req_light_level,
   input  logic [NB_W-1:0]    req_neighbor_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_stop_motors,
   output logic [KIND_W-1:0]  rsp_publish_kind,
   output logic [NB_W-1:0]    rsp_publish_value,
   // configuration write port
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [LIGHT_W-1:0] csr_wdata
);

   localparam int SUM_W  = $clog2(WINDOW_LEN * 32767 + 1);
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int DVD_W  = (SUM_W > COOL_NUM_W) ? SUM_W : COOL_NUM_W;
   localparam int DVS_W  = LIGHT_W;

   state_type          state_ff, state_in;

   // captured transaction
   req_code_type       code_ff, code_in;
   logic [TIME_W-1:0]  dt_ff, dt_in;
   logic               stopped_ff, stopped_in;
   logic [LIGHT_W-1:0] light_ff, light_in;
   logic [NB_W-1:0]    nb_ff, nb_in;

   // controller state
   logic               search_on_ff, search_on_in;
   logic               cool_active_ff, cool_active_in;
   logic [TIME_W-1:0]  wait_left_ff, wait_left_in;
   logic [TIME_W-1:0]  cool_left_ff, cool_left_in;
   logic [LIGHT_W-1:0] optimum_ff, optimum_in;
   logic [LIGHT_W-1:0] min_light_ff, min_light_in;
   logic [LIGHT_W-1:0] tolerance_ff, tolerance_in;

   // result register
   logic               stop_ff, stop_in;
   pub_kind_type       kind_ff, kind_in;
   logic [NB_W-1:0]    pval_ff, pval_in;

   // window and divider hookup
   logic               push;
   logic [LIGHT_W-1:0] push_value;
   logic [SUM_W-1:0]   win_sum;
   logic [FILL_W-1:0]  win_fill;
   logic               div_start;
   logic [DVD_W-1:0]   div_dividend;
   logic [DVS_W-1:0]   div_divisor;
   logic               div_done;
   logic [DVD_W-1:0]   div_quotient;

   // scratch values of the evaluation step
   logic [LIGHT_W:0]   stop_level;
   logic [LIGHT_W-1:0] light_diff;
   logic [LIGHT_W-1:0] nb_sat;
   logic [TIME_W-1:0]  cool_dec;
   logic [TIME_W-1:0]  wait_dec;

   always_comb begin
      stop_level = {1'b0, optimum_ff} + {1'b0, tolerance_ff};
      light_diff = light_ff - min_light_ff;
      nb_sat     = (nb_ff[NB_W-1]) ? Q78_MAX : {nb_ff[NB_W-2:0], 8'h00};
      cool_dec   = (cool_left_ff > dt_ff) ? (cool_left_ff - dt_ff) : '0;
      wait_dec   = (wait_left_ff > dt_ff) ? (wait_left_ff - dt_ff) : '0;
   end

   // Operands follow the step: cooldown divide out of evaluation, window mean
   // afterwards.
   assign div_dividend = (state_ff == ST_MEAN_GO) ? DVD_W'(win_sum) : DVD_W'(COOL_NUM);
   assign div_divisor  = (state_ff == ST_MEAN_GO) ? DVS_W'(win_fill) : light_diff;
   assign push_value   = (code_ff == REQ_NEIGHBOR) ? nb_sat : light_ff;

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      dt_in          = dt_ff;
      stopped_in     = stopped_ff;
      light_in       = light_ff;
      nb_in          = nb_ff;
      search_on_in   = search_on_ff;
      cool_active_in = cool_active_ff;
      wait_left_in   = wait_left_ff;
      cool_left_in   = cool_left_ff;
      optimum_in     = optimum_ff;
      min_light_in   = min_light_ff;
      tolerance_in   = tolerance_ff;
      stop_in        = stop_ff;
      kind_in        = kind_ff;
      pval_in        = pval_ff;
      push           = 1'b0;
      div_start      = 1'b0;

      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_LIGHT: min_light_in = csr_wdata;
            CSR_LIGHT_TOL: tolerance_in = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               code_in    = req_code_type'(req_type);
               dt_in      = req_elapsed_time;
               stopped_in = req_motors_stopped;
               light_in   = req_light_level;
               nb_in      = req_neighbor_value;
               state_in   = ST_EVAL;
            end
         end

         ST_EVAL: begin
            stop_in  = 1'b0;
            kind_in  = PUB_NONE;
            pval_in  = '0;
            state_in = ST_RESP;
            unique case (code_ff)
               REQ_TICK: begin
                  if (!search_on_ff) begin
                     stop_in = 1'b1;
                  end else if (cool_active_ff) begin
                     // count down the cooldown; release it at zero
                     cool_left_in = cool_dec;
                     if (cool_dec == '0) begin
                        cool_active_in = 1'b0;
                     end
                  end else if (!stopped_ff) begin
                     if ({1'b0, light_ff} >= stop_level) begin
                        stop_in = 1'b1;
                        kind_in = PUB_LIGHT;
                        pval_in = NB_W'(light_ff[LIGHT_W-1:8]);
                        if (light_ff > min_light_ff) begin
                           // wait = half the excess, cooldown = 10 / excess
                           wait_left_in = TIME_W'(light_diff >> 1);
                           div_start    = 1'b1;
                           push         = 1'b1;
                           state_in     = ST_COOL;
                        end else if (light_ff == min_light_ff) begin
                           wait_left_in = '0;
                           cool_left_in = TIME_MAX;
                        end else begin
                           wait_left_in = '0;
                           cool_left_in = '0;
                        end
                     end
                  end else begin
                     if ({light_ff, 1'b0} < {1'b0, optimum_ff}) begin
                        // light lost while parked: start over and tell neighbors
                        optimum_in     = min_light_ff;
                        wait_left_in   = '0;
                        cool_left_in   = '0;
                        cool_active_in = 1'b0;
                        kind_in        = PUB_RESET;
                     end else begin
                        wait_left_in = wait_dec;
                        if (wait_dec == '0) begin
                           cool_active_in = 1'b1;
                        end else begin
                           stop_in = 1'b1;
                        end
                     end
                  end
               end
               REQ_NEIGHBOR: begin
                  if (nb_sat > min_light_ff) begin
                     push     = 1'b1;
                     state_in = ST_MEAN_GO;
                  end
               end
               REQ_RESET: begin
                  optimum_in     = min_light_ff;
                  wait_left_in   = '0;
                  cool_left_in   = '0;
                  cool_active_in = 1'b0;
               end
               REQ_START: search_on_in = 1'b1;
               REQ_STOP:  search_on_in = 1'b0;
               default: begin
               end
            endcase
         end

         ST_COOL: begin
            if (div_done) begin
               cool_left_in = (div_quotient > DVD_W'(TIME_MAX)) ? TIME_MAX
                                                               : div_quotient[TIME_W-1:0];
               state_in     = ST_MEAN_GO;
            end
         end

         ST_MEAN_GO: begin
            div_start = 1'b1;
            state_in  = ST_MEAN;
         end

         ST_MEAN: begin
            if (div_done) begin
               optimum_in = (div_quotient >= DVD_W'(OPT_CAP)) ? OPT_CAP
                                                             : div_quotient[LIGHT_W-1:0];
               state_in   = ST_RESP;
            end
         end

         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         search_on_ff   <= 1'b1;
         cool_active_ff <= 1'b0;
         wait_left_ff   <= '0;
         cool_left_ff   <= '0;
         optimum_ff     <= MIN_LIGHT_RESET;
         min_light_ff   <= MIN_LIGHT_RESET;
         tolerance_ff   <= TOLERANCE_RESET;
      end else begin
         state_ff       <= state_in;
         search_on_ff   <= search_on_in;
         cool_active_ff <= cool_active_in;
         wait_left_ff   <= wait_left_in;
         cool_left_ff   <= cool_left_in;
         optimum_ff     <= optimum_in;
         min_light_ff   <= min_light_in;
         tolerance_ff   <= tolerance_in;
      end
      code_ff    <= code_in;
      dt_ff      <= dt_in;
      stopped_ff <= stopped_in;
      light_ff   <= light_in;
      nb_ff      <= nb_in;
      stop_ff    <= stop_in;
      kind_ff    <= kind_in;
      pval_ff    <= pval_in;
   end

   lasc_window #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W),
      .FILL_W     (FILL_W)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_value (push_value),
      .win_sum    (win_sum),
      .win_fill   (win_fill)
   );

   lasc_divider #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = (state_ff == ST_RESP);
   assign rsp_stop_motors   = stop_ff;
   assign rsp_publish_kind  = kind_ff;
   assign rsp_publish_value = pval_ff;

   // The two channels never overlap: one transaction is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response sides open at once");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EVAL))
      else $error("accepted transaction not evaluated next cycle");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_COOL || state_ff == ST_MEAN))
      else $error("divider finished outside a divide step");

   a_mean_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MEAN_GO) |-> (win_fill != '0))
      else $error("window mean started on an empty window");

endmodule

### tb/sv/light_aggregation_stop_controller_core_test.sv
// ----------------------------------------------------------------------------
// light_aggregation_stop_controller_core_test
// Self-checking bench for the stop/go controller. It sends ticks, neighbor
// values and commands, predicts every answer and compares it on arrival.
// ----------------------------------------------------------------------------
module light_aggregation_stop_controller_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lasc_pkg::*;

   // Highest light level a robot sensor reports (100.0 percent in Q7.8).
   localparam int LIGHT_TOP = 25600;
   // Request codes that the block must ignore.
   localparam logic [CODE_W-1:0] REQ_UNUSED_FIRST = 3'd5;
   localparam logic [CODE_W-1:0] REQ_UNUSED_LAST  = 3'd7;

   typedef struct {
      logic [CODE_W-1:0]  code;
      logic [TIME_W-1:0]  elapsed;
      logic               stopped;
      logic [LIGHT_W-1:0] light;
      logic [NB_W-1:0]    neighbor;
   } tick_request_type;

   typedef struct {
      logic              stop;
      logic [KIND_W-1:0] kind;
      logic [NB_W-1:0]   value;
   } controller_answer_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the controller state, the register values and
   // the answers still owed by the block.
   // -------------------------------------------------------------------------
   class stop_go_scoreboard;
      logic [LIGHT_W-1:0]    min_light;
      logic [LIGHT_W-1:0]    tolerance;
      logic [LIGHT_W-1:0]    optimum;
      logic [LIGHT_W-1:0]    readings [LASC_WINDOW_LEN];
      int unsigned           fill;
      bit                    searching;
      bit                    cooling;
      bit                    last_stop;
      logic [TIME_W-1:0]     wait_left;
      logic [TIME_W-1:0]     cool_left;
      controller_answer_type awaited_answers [$];
      int                    mismatch_count;

      function new();
         min_light      = MIN_LIGHT_RESET;
         tolerance      = TOLERANCE_RESET;
         searching      = 1'b1;
         last_stop      = 1'b0;
         fill           = 0;
         mismatch_count = 0;
         foreach (readings[i]) readings[i] = '0;
         clear_control();
      endfunction

      function void set_register(csr_index_type idx, logic [LIGHT_W-1:0] value);
         if (idx == CSR_MIN_LIGHT) min_light = value;
         else tolerance = value;
      endfunction

      function void clear_control();
         optimum   = min_light;
         wait_left = '0;
         cool_left = '0;
         cooling   = 1'b0;
      endfunction

      // Shift a reading above the minimum into the window and refresh the capped mean.
      function void add_reading(int unsigned v);
         int unsigned sum;
         int unsigned mean;
         if (v <= min_light) return;
         if (fill < LASC_WINDOW_LEN) fill++;
         for (int i = 0; i < LASC_WINDOW_LEN - 1; i++) readings[i] = readings[i + 1];
         readings[LASC_WINDOW_LEN - 1] = v[LIGHT_W-1:0];
         sum = 0;
         for (int i = 0; i < fill; i++) sum += readings[LASC_WINDOW_LEN - 1 - i];
         mean = sum / fill;
         optimum = (mean >= OPT_CAP) ? OPT_CAP : mean[LIGHT_W-1:0];
      endfunction

      function controller_answer_type predict_answer(tick_request_type r);
         controller_answer_type a;
         int unsigned light_v;
         int unsigned min_v;
         int unsigned opt_v;
         int unsigned d;
         int unsigned quot;
         int unsigned nb_q;
         a.stop  = 1'b0;
         a.kind  = PUB_NONE;
         a.value = '0;
         light_v = int'(r.light);
         min_v   = int'(min_light);
         opt_v   = int'(optimum);
         unique case (r.code)
            REQ_TICK: begin
               if (!searching) begin
                  a.stop = 1'b1;
               end else if (cooling) begin
                  cool_left = (cool_left > r.elapsed) ? cool_left - r.elapsed : '0;
                  if (cool_left == 0) cooling = 1'b0;
               end else if (!r.stopped) begin
                  if (light_v >= opt_v + int'(tolerance)) begin
                     if (light_v > min_v) begin
                        d         = light_v - min_v;
                        quot      = COOL_NUM / d;
                        wait_left = TIME_W'(d >> 1);
                        cool_left = (quot > TIME_MAX) ? TIME_MAX : TIME_W'(quot);
                     end else if (light_v == min_v) begin
                        wait_left = '0;
                        cool_left = TIME_MAX;
                     end else begin
                        wait_left = '0;
                        cool_left = '0;
                     end
                     add_reading(light_v);
                     a.stop  = 1'b1;
                     a.kind  = PUB_LIGHT;
                     a.value = NB_W'(r.light[LIGHT_W-1:8]);
                  end
               end else begin
                  if (2 * light_v < opt_v) begin
                     clear_control();
                     a.kind = PUB_RESET;
                  end else begin
                     wait_left = (wait_left > r.elapsed) ? wait_left - r.elapsed : '0;
                     if (wait_left == 0) cooling = 1'b1;
                     else a.stop = 1'b1;
                  end
               end
               last_stop = a.stop;
            end
            REQ_NEIGHBOR: begin
               nb_q = int'(r.neighbor) << 8;
               add_reading((nb_q > Q78_MAX) ? Q78_MAX : nb_q);
            end
            REQ_RESET: clear_control();
            REQ_START: searching = 1'b1;
            REQ_STOP:  searching = 1'b0;
            default: ;
         endcase
         return a;
      endfunction

      function void note_request(tick_request_type r);
         awaited_answers.push_back(predict_answer(r));
      endfunction

      function void check_response(controller_answer_type got);
         controller_answer_type want;
         if (awaited_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected answer: stop=%0d kind=%0d value=%0d",
                        got.stop, got.kind, got.value);
            return;
         end
         want = awaited_answers.pop_front();
         if (got.stop !== want.stop || got.kind !== want.kind || got.value !== want.value) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display({"answer mismatch: expected stop=%0d kind=%0d value=%0d,",
                         " got stop=%0d kind=%0d value=%0d"},
                        want.stop, want.kind, want.value, got.stop, got.kind, got.value);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and block under test
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset              = 1'b1;
   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic [CODE_W-1:0]  req_type           = '0;
   logic [TIME_W-1:0]  req_elapsed_time   = '0;
   logic               req_motors_stopped = 1'b0;
   logic [LIGHT_W-1:0] req_light_level    = '0;
   logic [NB_W-1:0]    req_neighbor_value = '0;
   logic               rsp_valid;
   logic               rsp_ready          = 1'b0;
   logic               rsp_stop_motors;
   logic [KIND_W-1:0]  rsp_publish_kind;
   logic [NB_W-1:0]    rsp_publish_value;
   logic               csr_write_en       = 1'b0;
   logic               csr_index          = 1'b0;
   logic [LIGHT_W-1:0] csr_wdata          = '0;

   stop_go_scoreboard tracker;
   bit                idle_on       = 1'b1;  // allow gaps and stalls right now
   bit                final_stretch = 1'b0;  // no idling at all in the last phase
   int                stall_left    = 0;

   light_aggregation_stop_controller_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #6_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Result side: check every transaction taken, and stall rsp_ready in
   // random bursts that ignore rsp_valid so they hit every phase of the work.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready)
         tracker.check_response(controller_answer_type'{rsp_stop_motors, rsp_publish_kind,
                                                        rsp_publish_value});
      if (stall_left > 0) stall_left--;
      if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 14);
      rsp_ready <= (stall_left == 0);
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Present one transaction and hold it until accepted. Valid stays high
   // afterward so that back-to-back transactions never toggle it; the next
   // call drops it only when it opens a gap.
   task automatic send_request(input tick_request_type r);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= r.code;
      req_elapsed_time   <= r.elapsed;
      req_motors_stopped <= r.stopped;
      req_light_level    <= r.light;
      req_neighbor_value <= r.neighbor;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(r);
   endtask

   // Drop valid and wait until every answer is in and the block has gone idle.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (tracker.awaited_answers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [LIGHT_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   function automatic tick_request_type make_request(logic [CODE_W-1:0] code,
                                                    logic [TIME_W-1:0] elapsed, logic stopped,
                                                    logic [LIGHT_W-1:0] light,
                                                    logic [NB_W-1:0] neighbor);
      tick_request_type r;
      r.code     = code;
      r.elapsed  = elapsed;
      r.stopped  = stopped;
      r.light    = light;
      r.neighbor = neighbor;
      return r;
   endfunction

   // Bias light readings toward the interesting spots: the stop threshold,
   // the minimum, the reset zone under half the optimum, and bright light.
   function automatic logic [LIGHT_W-1:0] pick_light();
      int thr;
      int v;
      thr = int'(tracker.optimum) + int'(tracker.tolerance);
      case ($urandom_range(0, 9))
         0, 1:    v = thr + int'($urandom_range(0, 6)) - 3;
         2:       v = int'(tracker.min_light) + int'($urandom_range(0, 2)) - 1;
         3, 4:    v = int'($urandom_range(0, tracker.optimum / 2));
         5, 6, 7: v = int'($urandom_range(0, LIGHT_TOP));
         default: v = (thr >= LIGHT_TOP) ? LIGHT_TOP : int'($urandom_range(thr, LIGHT_TOP));
      endcase
      if (v < 0) v = 0;
      if (v > LIGHT_TOP) v = LIGHT_TOP;
      return v[LIGHT_W-1:0];
   endfunction

   // Mostly ticks that follow the motor state the controller asked for, so
   // stop, wait and cooldown cycles run through; commands and noise between.
   function automatic tick_request_type random_request();
      tick_request_type r;
      int unsigned      sel;
      sel = $urandom_range(0, 99);
      if (!tracker.searching && sel < 30) r.code = REQ_START;
      else if (sel < 80) r.code = REQ_TICK;
      else if (sel < 88) r.code = REQ_NEIGHBOR;
      else if (sel < 91) r.code = REQ_RESET;
      else if (sel < 94) r.code = REQ_START;
      else if (sel < 97) r.code = REQ_STOP;
      else r.code = CODE_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
      case ($urandom_range(0, 9))
         0:       r.elapsed = '0;
         1:       r.elapsed = TIME_MAX;
         2:       r.elapsed = TIME_W'($urandom_range(0, TIME_MAX));
         default: r.elapsed = TIME_W'($urandom_range(1, 1500));
      endcase
      r.stopped  = ($urandom_range(0, 6) == 0) ? 1'($urandom_range(0, 1)) : tracker.last_stop;
      r.light    = pick_light();
      r.neighbor = NB_W'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         // Switch idling on and off in stretches of thirty transactions.
         if (i % 30 == 0) idle_on = !final_stretch && ($urandom_range(0, 3) != 0);
         send_request(random_request());
      end
   endtask

   task automatic run_phase(input logic [LIGHT_W-1:0] min_v, input logic [LIGHT_W-1:0] tol_v,
                            input int count);
      settle_block();
      write_csr(CSR_MIN_LIGHT, min_v);
      write_csr(CSR_LIGHT_TOL, tol_v);
      run_random(count);
   endtask

   task automatic run_directed();
      // Full stop cycle with the default registers: ignore dim light, stop on
      // bright light, wait, cool down, then a reset notice on darkness.
      send_request(make_request(REQ_TICK, '0, 1'b0, '0, '0));
      send_request(make_request(REQ_TICK, '0, 1'b0, LIGHT_TOP, '0));
      send_request(make_request(REQ_TICK, '0, 1'b1, LIGHT_TOP, '0));
      send_request(make_request(REQ_TICK, TIME_MAX, 1'b1, LIGHT_TOP, '0));
      send_request(make_request(REQ_TICK, 16'd10, 1'b0, LIGHT_TOP, '0));
      send_request(make_request(REQ_TICK, TIME_MAX, 1'b0, LIGHT_TOP, '0));
      send_request(make_request(REQ_TICK, '0, 1'b1, '0, '0));
      // Neighbor values: saturating, ignored at the minimum, ordinary.
      send_request(make_request(REQ_NEIGHBOR, '0, 1'b0, '0, 8'hFF));
      send_request(make_request(REQ_NEIGHBOR, '0, 1'b0, '0, '0));
      send_request(make_request(REQ_NEIGHBOR, '0, 1'b0, '0, 8'd90));
      send_request(make_request(REQ_RESET, TIME_MAX, 1'b1, LIGHT_TOP, 8'hFF));
      for (int c = REQ_UNUSED_FIRST; c <= REQ_UNUSED_LAST; c++)
         send_request(make_request(CODE_W'(c), TIME_MAX, 1'b1, LIGHT_TOP, 8'hFF));
      // Search off holds the motors whatever the tick says.
      send_request(make_request(REQ_STOP, '0, 1'b0, '0, '0));
      send_request(make_request(REQ_TICK, 16'd100, 1'b0, LIGHT_TOP, '0));
      send_request(make_request(REQ_TICK, 16'd100, 1'b1, '0, '0));
      send_request(make_request(REQ_START, '0, 1'b0, '0, '0));
      send_request(make_request(REQ_TICK, '0, 1'b0, LIGHT_TOP, '0));
      // Stop with light exactly at the minimum: no wait, longest cooldown.
      settle_block();
      write_csr(CSR_LIGHT_TOL, '0);
      send_request(make_request(REQ_RESET, '0, 1'b0, '0, '0));
      send_request(make_request(REQ_TICK, '0, 1'b0, '0, '0));
      send_request(make_request(REQ_RESET, '0, 1'b0, '0, '0));
      // Raise the minimum above a stale optimum: stop with light below it.
      settle_block();
      write_csr(CSR_MIN_LIGHT, 15'(LIGHT_TOP));
      send_request(make_request(REQ_TICK, '0, 1'b0, 15'(LIGHT_TOP - 1), '0));
      send_request(make_request(REQ_TICK, '0, 1'b0, 15'(LIGHT_TOP), '0));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_phase(MIN_LIGHT_RESET, TOLERANCE_RESET, 60);
      // Register extremes.
      run_phase('0, '0, 60);
      run_phase(15'(LIGHT_TOP), 15'(LIGHT_TOP), 40);
      run_phase(15'(LIGHT_TOP), '0, 40);
      run_phase('0, 15'(LIGHT_TOP), 40);
      // Ordinary settings, mostly a low minimum so that stops stay common.
      for (int p = 0; p < 3; p++) begin
         if (p == 2) begin
            final_stretch = 1'b1;
            idle_on       = 1'b0;
         end
         run_phase(($urandom_range(0, 9) < 7) ? 15'($urandom_range(0, 6400))
                                              : 15'($urandom_range(0, LIGHT_TOP)),
                   15'($urandom_range(0, 3000)), 70);
      end

      settle_block();
      repeat (60) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.awaited_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
